[hdl/tpa_pkg.sv]
// Package for triangle primitive assembly: payload structs, mode codes,
// register indexes and sizing constants. No dependencies.
`default_nettype none

package tpa_pkg;

   localparam int INDEX_WIDTH       = 16;
   localparam int MODE_WIDTH        = 2;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = MODE_WIDTH;
   localparam int TPA_QUEUE_DEPTH   = 4;
   localparam int WARMUP_WIDTH      = 2;
   localparam int PHASE_WIDTH       = 2;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_LIST  = 2'd0,
      MODE_STRIP = 2'd1,
      MODE_FAN   = 2'd2
   } assembly_mode_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ASSEMBLY_MODE       = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPEN_CYLINDER_FACES = 1'd1;

   localparam logic [WARMUP_WIDTH-1:0] WARMUP_FULL = 2'd2;
   localparam logic [PHASE_WIDTH-1:0]  PHASE_LAST  = 2'd2;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] vertex_index;
      logic                   starts_group;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] corner_a;
      logic [INDEX_WIDTH-1:0] corner_b;
      logic [INDEX_WIDTH-1:0] corner_c;
      logic                   face_kind;
   } rsp_payload_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tpa_queue_status_type;

endpackage

`default_nettype wire

[hdl/triangle_primitive_assembly.sv]
// Top level of triangle primitive assembly: front end, triangle queue and
// output stage. Uses tpa_pkg, tpa_front, tpa_queue, tpa_back.
`default_nettype none

// Usage
//   req_*: one vertex beat per accepted handshake (vertex_index, starts_group).
//     The first vertex after reset opens a group even without the flag.
//   rsp_*: one triangle beat (corner_a, corner_b, corner_c, face_kind) for each
//     vertex that closes a triangle in the current mode; other vertices only
//     advance the history.
//   csr_*: write assembly_mode (index 0) and open_cylinder_faces (index 1)
//     only while no triangle is pending.
// Timing
//   A vertex is classified in the cycle it is accepted; its triangle enters
//   the queue at that edge and reaches rsp_valid through the output register.
//   Throughput is one vertex per cycle while the queue has room, set by the front
//   end's history update and the output register's one-beat-per-cycle drain.
// Reset and stall
//   Synchronous reset clears the configuration registers, the group counters,
//   the queue and the output valid. While rsp_ready is low the output beat holds
//   and the queue fills; req_ready drops only when the queue is full.
module triangle_primitive_assembly
   import tpa_pkg::*;
#(
   parameter int QUEUE_DEPTH = TPA_QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire req_payload_type            req_payload,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      rsp_payload_type            rsp_payload,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // Queue status goes to both sides so each stalls on its own.
   tpa_queue_status_type queue_status;
   logic                 push;
   logic                 pop;
   rsp_payload_type      push_payload;
   rsp_payload_type      head_payload;

   // Classify vertices, hold config and history.
   tpa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .push             (push),
      .push_payload     (push_payload)
   );

   // Buffer finished triangles.
   tpa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_payload (push_payload),
      .pop          (pop),
      .head_payload (head_payload),
      .status       (queue_status)
   );

   // Drive the result channel from a register.
   tpa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_payload (head_payload),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire

[hdl/tpa_front.sv]
// Front end: configuration registers, vertex history and group counters.
// Classifies each vertex and pushes a finished triangle. Uses tpa_pkg.
`default_nettype none

module tpa_front
   import tpa_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire req_payload_type            req_payload,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  wire tpa_queue_status_type       queue_status,
   output      logic                       push,
   output      rsp_payload_type            push_payload
);

   logic [MODE_WIDTH-1:0]   mode_ff;
   logic                    open_cyl_ff;
   logic [INDEX_WIDTH-1:0]  group_first_ff, group_first_in;
   logic [INDEX_WIDTH-1:0]  prev_ff;
   logic [INDEX_WIDTH-1:0]  prev2_ff;
   logic [PHASE_WIDTH-1:0]  phase_ff, phase_in;
   logic                    odd_ff, odd_in;
   logic [WARMUP_WIDTH-1:0] warmup_ff, warmup_in;

   logic                    accept;
   logic [PHASE_WIDTH-1:0]  phase_eff;
   logic                    odd_eff;
   logic [WARMUP_WIDTH-1:0] warmup_eff;
   logic                    emit;
   logic [INDEX_WIDTH-1:0]  v;

   assign req_ready = ~queue_status.full;
   assign accept    = req_valid & req_ready;
   assign v         = req_payload.vertex_index;

   // A start flag restarts the group position before this vertex is used.
   always_comb begin
      warmup_eff     = req_payload.starts_group ? '0 : warmup_ff;
      phase_eff      = req_payload.starts_group ? '0 : phase_ff;
      odd_eff        = req_payload.starts_group ? 1'b0 : odd_ff;
      group_first_in = (warmup_eff == '0) ? v : group_first_ff;
      warmup_in      = (warmup_eff == WARMUP_FULL) ? WARMUP_FULL
                                                   : warmup_eff + WARMUP_WIDTH'(1);
      phase_in       = (phase_eff == PHASE_LAST) ? '0 : phase_eff + PHASE_WIDTH'(1);
      odd_in         = ~odd_eff;
   end

   always_comb begin
      emit                   = 1'b0;
      push_payload.corner_a  = prev2_ff;
      push_payload.corner_b  = prev_ff;
      push_payload.corner_c  = v;
      push_payload.face_kind = open_cyl_ff;
      unique case (mode_ff)
         MODE_LIST: begin
            emit = (phase_eff == PHASE_LAST);
         end
         MODE_STRIP: begin
            emit = (warmup_eff == WARMUP_FULL);
            if (odd_eff) begin
               push_payload.corner_a = v;
               push_payload.corner_c = prev2_ff;
            end
         end
         MODE_FAN: begin
            emit                  = (warmup_eff == WARMUP_FULL);
            push_payload.corner_a = prev_ff;
            push_payload.corner_b = v;
            push_payload.corner_c = group_first_in;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign push = accept & emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_LIST;
         open_cyl_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ASSEMBLY_MODE:       mode_ff     <= csr_write_data;
            CSR_OPEN_CYLINDER_FACES: open_cyl_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         odd_ff    <= 1'b0;
         warmup_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         odd_ff    <= odd_in;
         warmup_ff <= warmup_in;
      end
   end

   // History needs no reset: warmup and phase at zero keep it from being used.
   always_ff @(posedge clock) begin
      if (accept) begin
         group_first_ff <= group_first_in;
         prev2_ff       <= prev_ff;
         prev_ff        <= v;
      end
   end

endmodule

`default_nettype wire

[hdl/tpa_queue.sv]
// Short triangle queue between the front end and the output stage.
// Register-based circular buffer. Uses tpa_pkg.
`default_nettype none

module tpa_queue
   import tpa_pkg::*;
#(
   parameter int DEPTH = TPA_QUEUE_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire rsp_payload_type push_payload,
   input  wire logic            pop,
   output      rsp_payload_type head_payload,
   output tpa_queue_status_type status
);

   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   rsp_payload_type        entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == COUNT_WIDTH'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_payload = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_payload;
      end
   end

endmodule

`default_nettype wire

[hdl/tpa_back.sv]
// Back end: output register that drains the triangle queue onto the
// result channel. Uses tpa_pkg.
`default_nettype none

module tpa_back
   import tpa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpa_queue_status_type queue_status,
   input  wire rsp_payload_type      head_payload,
   output      logic                 pop,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_payload_type      rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff;

   // Load a new beat, if the queue holds one, whenever the register is empty or being taken.
   assign pop      = ~queue_status.empty & (~valid_ff | rsp_ready);
   assign valid_in = pop | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         payload_ff <= head_payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

`default_nettype wire

[hdl/tpa_checker.sv]
// Port-level checker for triangle primitive assembly, bound to the top
// level. Uses tpa_pkg.
`default_nettype none

module tpa_checker
   import tpa_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_payload
);

   // Reset empties the output stage.
   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Reset empties the queue, so input is open at once.
   a_reset_opens_input: assert property (@(posedge clock) reset |=> req_ready)
      else $error("req_ready low after reset");

   // Back pressure on input only comes from a pending output beat.
   a_full_implies_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no result pending");

   // A stalled beat holds.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind triangle_primitive_assembly tpa_checker u_tpa_checker (.*);

`default_nettype wire

[tb/triangle_primitive_assembly_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for triangle_primitive_assembly: vertex stream in,
// triangle beats out, checked against an in-bench assembly predictor.
// Depends on tpa_pkg and the triangle_primitive_assembly RTL only.

module triangle_primitive_assembly_tb
   import tpa_pkg::*;
();

   // Mode code that the block must treat as "emit nothing"
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_VERTICES = 1750;
   // Cycles to let the output stage settle once nothing is expected
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = CSR_ASSEMBLY_MODE;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   // Vertices waiting to be driven, triangles waiting to be seen
   req_payload_type pending_vertices[$];
   rsp_payload_type pending_triangles[$];

   int error_count = 0;
   int cycle_count = 0;

   // Idle controls, retuned per phase by the stimulus block
   logic send_idle_on = 1'b1;
   logic recv_idle_on = 1'b1;
   int   send_gap     = 0;
   int   recv_stall   = 0;

   // Predictor copy of the registers and the assembly history
   logic [MODE_WIDTH-1:0]   mode_setting  = MODE_LIST;
   logic                    faces_setting = 1'b0;
   logic [INDEX_WIDTH-1:0]  group_first   = '0;
   logic [INDEX_WIDTH-1:0]  last_vertex   = '0;
   logic [INDEX_WIDTH-1:0]  older_vertex  = '0;
   logic [PHASE_WIDTH-1:0]  triple_phase  = '0;
   logic                    odd_slot      = 1'b0;
   logic [WARMUP_WIDTH-1:0] warmup        = '0;

   triangle_primitive_assembly u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly back-to-back, some short pauses, a few long ones
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Advance the assembly history by one vertex; return 1 when it closes a triangle.
   function automatic logic assemble_vertex(input req_payload_type vertex,
                                            output rsp_payload_type triangle);
      logic                   closes;
      logic [INDEX_WIDTH-1:0] v;
      closes   = 1'b0;
      v        = vertex.vertex_index;
      triangle = '0;
      // A group flag restarts every counter
      if (vertex.starts_group) begin
         warmup       = '0;
         triple_phase = '0;
         odd_slot     = 1'b0;
      end
      // Warmup at zero also covers the very first vertex after reset
      if (warmup == '0)
         group_first = v;
      case (mode_setting)
         MODE_LIST: begin
            if (triple_phase == PHASE_LAST) begin
               closes = 1'b1;
               triangle.corner_a = older_vertex;
               triangle.corner_b = last_vertex;
               triangle.corner_c = v;
            end
         end
         MODE_STRIP: begin
            if (warmup == WARMUP_FULL) begin
               closes = 1'b1;
               // Odd positions flip the winding
               triangle.corner_a = odd_slot ? v : older_vertex;
               triangle.corner_b = last_vertex;
               triangle.corner_c = odd_slot ? older_vertex : v;
            end
         end
         MODE_FAN: begin
            if (warmup == WARMUP_FULL) begin
               closes = 1'b1;
               triangle.corner_a = last_vertex;
               triangle.corner_b = v;
               triangle.corner_c = group_first;
            end
         end
         default: begin
         end
      endcase
      triangle.face_kind = faces_setting;
      // History and counters move in every mode, the unused one included
      older_vertex = last_vertex;
      last_vertex  = v;
      if (warmup < WARMUP_FULL)
         warmup = warmup + 1'b1;
      triple_phase = (triple_phase >= PHASE_LAST) ? '0 : triple_phase + 1'b1;
      odd_slot     = ~odd_slot;
      return closes;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Driver: predict on every accepted beat, then present the next one or idle.
   always @(posedge clock) begin
      rsp_payload_type triangle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (assemble_vertex(req_payload, triangle))
               pending_triangles.insert(pending_triangles.size(), triangle);
         end
         // Hold the beat until it is taken
         if (!req_valid || req_ready) begin
            if (send_gap != 0 || pending_vertices.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap != 0)
                  send_gap--;
            end else begin
               req_valid   <= 1'b1;
               req_payload <= pending_vertices.pop_front();
               send_gap     = send_idle_on ? draw_gap() : 0;
            end
         end
      end
   end

   // Receiver backpressure: stretches of stall between ready cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall != 0) begin
         rsp_ready <= 1'b0;
         recv_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (recv_idle_on && $urandom_range(0, 99) < 25)
            recv_stall = draw_gap();
      end
   end

   // Monitor: compare each triangle beat with the oldest expected one.
   always @(posedge clock) begin
      rsp_payload_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_triangles.size() == 0) begin
            flag_mismatch($sformatf("unexpected triangle %h", rsp_payload));
         end else begin
            wanted = pending_triangles.pop_front();
            if (rsp_payload.corner_a !== wanted.corner_a)
               flag_mismatch($sformatf("corner_a %h, want %h",
                                       rsp_payload.corner_a, wanted.corner_a));
            if (rsp_payload.corner_b !== wanted.corner_b)
               flag_mismatch($sformatf("corner_b %h, want %h",
                                       rsp_payload.corner_b, wanted.corner_b));
            if (rsp_payload.corner_c !== wanted.corner_c)
               flag_mismatch($sformatf("corner_c %h, want %h",
                                       rsp_payload.corner_c, wanted.corner_c));
            if (rsp_payload.face_kind !== wanted.face_kind)
               flag_mismatch($sformatf("face_kind %b, want %b",
                                       rsp_payload.face_kind, wanted.face_kind));
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_vertex(input logic [INDEX_WIDTH-1:0] index, input logic flag);
      req_payload_type vertex;
      vertex.vertex_index = index;
      vertex.starts_group = flag;
      pending_vertices.insert(pending_vertices.size(), vertex);
   endtask

   // Wait out every queued vertex and expected triangle, then let the
   // pipeline empty of vertices that closed nothing. Sample on the falling
   // edge so the driver and monitor have finished with the rising one.
   task automatic drain_and_settle();
      do
         @(negedge clock);
      while (pending_vertices.size() != 0 || req_valid || pending_triangles.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register while the block is idle; track it in the predictor.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_ASSEMBLY_MODE)
         mode_setting = data;
      else if (index == CSR_OPEN_CYLINDER_FACES)
         faces_setting = data[0];
   endtask

   // Fill one phase with groups of random length and content. Most groups
   // are well formed; a few carry a stray or missing flag. The first group
   // may continue the previous phase's group so a mode switch lands mid-group.
   task automatic queue_random_phase(input int count);
      int  left;
      int  group_len;
      int  pick;
      logic flag;
      logic [INDEX_WIDTH-1:0] index;
      logic carry_on;
      left     = count;
      carry_on = ($urandom_range(0, 3) == 0);
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            group_len = $urandom_range(1, 2);
         else if (pick < 85)
            group_len = $urandom_range(3, 9);
         else
            group_len = $urandom_range(10, 30);
         for (int k = 0; k < group_len && left > 0; k++) begin
            flag = (k == 0) && !carry_on;
            // Noise: flip the group flag now and then
            if ($urandom_range(0, 99) < 4)
               flag = ~flag;
            pick = $urandom_range(0, 99);
            if (pick < 5)
               index = '0;
            else if (pick < 10)
               index = '1;
            else
               index = INDEX_WIDTH'($urandom_range(0, 65535));
            queue_vertex(index, flag);
            left--;
         end
         carry_on = 1'b0;
      end
   endtask

   initial begin
      int issued;
      int phase_num;
      int count;
      logic [MODE_WIDTH-1:0] mode;
      logic                  faces;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // List mode from reset defaults; the first vertex opens a group without
      // its flag, and a leftover pair is dropped when the next group starts.
      queue_vertex(16'hFFFF, 1'b0);
      queue_vertex(16'h0000, 1'b0);
      queue_vertex(16'h8001, 1'b0);
      queue_vertex(16'h0001, 1'b0);
      queue_vertex(16'h0002, 1'b0);
      queue_vertex(16'h5555, 1'b1);
      queue_vertex(16'hAAAA, 1'b0);
      queue_vertex(16'h1234, 1'b0);
      drain_and_settle();

      // Strip with both windings; face bit written with its excess bit set.
      write_register(CSR_ASSEMBLY_MODE, MODE_STRIP);
      write_register(CSR_OPEN_CYLINDER_FACES, 2'b11);
      queue_vertex(16'h0010, 1'b1);
      queue_vertex(16'h0011, 1'b0);
      queue_vertex(16'h0012, 1'b0);
      queue_vertex(16'h0013, 1'b0);
      queue_vertex(16'h0014, 1'b0);
      // Short group emits nothing
      queue_vertex(16'h0020, 1'b1);
      queue_vertex(16'h0021, 1'b0);
      queue_vertex(16'h0030, 1'b1);
      drain_and_settle();

      // Fan; excess bit alone must leave the face bit clear.
      write_register(CSR_ASSEMBLY_MODE, MODE_FAN);
      write_register(CSR_OPEN_CYLINDER_FACES, 2'b10);
      queue_vertex(16'h0040, 1'b1);
      queue_vertex(16'h0041, 1'b0);
      queue_vertex(16'h0042, 1'b0);
      queue_vertex(16'hFFFF, 1'b0);
      drain_and_settle();

      // Unused mode emits nothing but keeps counting; then switch to list
      // in the middle of that group.
      write_register(CSR_ASSEMBLY_MODE, MODE_UNUSED);
      queue_vertex(16'h0050, 1'b1);
      queue_vertex(16'h0051, 1'b0);
      queue_vertex(16'h0052, 1'b0);
      queue_vertex(16'h0053, 1'b0);
      drain_and_settle();
      write_register(CSR_ASSEMBLY_MODE, MODE_LIST);
      queue_vertex(16'h0054, 1'b0);
      queue_vertex(16'h0055, 1'b0);
      drain_and_settle();

      // Random phases, each with its own settings and idle pattern.
      issued    = 0;
      phase_num = 0;
      while (issued < RANDOM_VERTICES) begin
         if (phase_num < 4)
            mode = (phase_num == 3) ? MODE_UNUSED : MODE_WIDTH'(phase_num);
         else if ($urandom_range(0, 9) == 0)
            mode = MODE_UNUSED;
         else
            mode = MODE_WIDTH'($urandom_range(MODE_LIST, MODE_FAN));
         faces = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1) != 0) begin
            write_register(CSR_ASSEMBLY_MODE, mode);
            write_register(CSR_OPEN_CYLINDER_FACES, {1'($urandom_range(0, 1)), faces});
         end else begin
            write_register(CSR_OPEN_CYLINDER_FACES, {1'($urandom_range(0, 1)), faces});
            write_register(CSR_ASSEMBLY_MODE, mode);
         end
         // Some phases run with no idling on one side or both
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         count = $urandom_range(60, 190);
         queue_random_phase(count);
         issued += count;
         phase_num++;
         drain_and_settle();
      end

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
